>>> src/set_assoc_cache_tag_engine_unit_macros.svh
// assertion macros of the tag engine unit
`ifndef SET_ASSOC_CACHE_TAG_ENGINE_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SACTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SACTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sacte_pkg.sv
// shared types, constants and helpers of the cache tag engine
`timescale 1ns / 1ps
package sacte_pkg;

    localparam int WAYS_DEF       = 8;
    localparam int SETS_DEF       = 256;
    localparam int ADDR_BITS_DEF  = 48;
    localparam int STAMP_BITS_DEF = 32;

    localparam int TOTAL_W     = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;
    localparam int WAY_IDX_MAX = 4;

    localparam logic [3:0] OFFSET_BITS_RST = 4'd6;
    localparam logic [3:0] SET_BITS_RST    = 4'd8;
    localparam logic [3:0] WAYS_IN_USE_RST = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPLACE_LRU     = 3'd0,
        CFG_PREFETCH_ENABLE = 3'd1,
        CFG_OFFSET_BITS     = 3'd2,
        CFG_SET_BITS        = 3'd3,
        CFG_WAYS_IN_USE     = 3'd4
    } cfg_idx_t;

    // outcome of one set lookup
    typedef struct packed {
        logic                   hit;
        logic [WAY_IDX_MAX-1:0] way;
    } sel_t;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        logic [TOTAL_W-1:0] r;
        r = (v == {TOTAL_W{1'b1}}) ? v : v + TOTAL_W'(1);
        return r;
    endfunction

endpackage

>>> src/sacte_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module sacte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/sacte_way_sel.sv
// tag compare and victim choice over one set row
`timescale 1ns / 1ps
module sacte_way_sel #(
    parameter int WAYS       = sacte_pkg::WAYS_DEF,
    parameter int ADDR_BITS  = sacte_pkg::ADDR_BITS_DEF,
    parameter int STAMP_BITS = sacte_pkg::STAMP_BITS_DEF
) (
    input  logic [WAYS*(1+ADDR_BITS+2*STAMP_BITS)-1:0] row,
    input  logic [ADDR_BITS-1:0]                       tag,
    input  logic [$clog2(WAYS+1)-1:0]                  nw,
    input  logic                                       lru,
    output sacte_pkg::sel_t                            sel
);
    import sacte_pkg::*;

    localparam int WAY_W  = 1 + ADDR_BITS + 2 * STAMP_BITS;
    localparam int TAG_O  = 1;
    localparam int FILL_O = 1 + ADDR_BITS;
    localparam int USE_O  = 1 + ADDR_BITS + STAMP_BITS;
    localparam int IW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LVLS   = $clog2(WAYS);
    localparam int P      = 1 << LVLS;
    localparam int NW_W   = $clog2(WAYS + 1);

    always_comb
    begin
        logic                  found_hit;
        logic                  found_inv;
        logic [IW-1:0]         hit_w;
        logic [IW-1:0]         inv_w;
        logic                  c  [P];
        logic [STAMP_BITS-1:0] st [P];
        logic [IW-1:0]         ix [P];
        logic                  in_use;
        logic                  vld;
        logic                  take_b;
        found_hit = 1'b0;
        found_inv = 1'b0;
        hit_w     = '0;
        inv_w     = '0;
        for (int i = 0; i < P; i++)
        begin
            c[i]  = 1'b0;
            st[i] = '0;
            ix[i] = IW'(i);
        end
        for (int w = 0; w < WAYS; w++)
        begin
            in_use = (NW_W'(w) < nw);
            vld    = row[w*WAY_W];
            if (in_use && vld && row[w*WAY_W+TAG_O +: ADDR_BITS] == tag && !found_hit)
            begin
                found_hit = 1'b1;
                hit_w     = IW'(w);
            end
            if (in_use && !vld && !found_inv)
            begin
                found_inv = 1'b1;
                inv_w     = IW'(w);
            end
            c[w]  = in_use;
            st[w] = lru ? row[w*WAY_W+USE_O +: STAMP_BITS]
                        : row[w*WAY_W+FILL_O +: STAMP_BITS];
        end
        // pairwise minimum tree, ties keep the lower way
        for (int l = 0; l < LVLS; l++)
        begin
            for (int i = 0; i < (P >> (l + 1)); i++)
            begin
                take_b = c[2*i+1] && (!c[2*i] || st[2*i+1] < st[2*i]);
                c[i]   = take_b ? c[2*i+1]  : c[2*i];
                st[i]  = take_b ? st[2*i+1] : st[2*i];
                ix[i]  = take_b ? ix[2*i+1] : ix[2*i];
            end
        end
        sel.hit = found_hit;
        if (found_hit)
        begin
            sel.way = WAY_IDX_MAX'(hit_w);
        end
        else if (found_inv)
        begin
            sel.way = WAY_IDX_MAX'(inv_w);
        end
        else
        begin
            sel.way = WAY_IDX_MAX'(ix[0]);
        end
    end

endmodule

>>> src/set_assoc_cache_tag_engine_unit.sv
// Set-associative write-through cache tag engine, FIFO or LRU, next-line prefetch.
// One set row (all ways: valid, tag, fill stamp, use stamp) lives in a single
// ram word. After reset the engine clears the ram one row a cycle and accepts
// no request meanwhile. A request then passes through a lookup state, in which the
// row read at acceptance is compared, the victim chosen and the row written back,
// then a done state; a demand miss with prefetch on adds a prefetch lookup state
// for the next-line row. The next request may be accepted in the done state once
// the output is free. Config writes are taken at any time with ready held high.
`timescale 1ns / 1ps
module set_assoc_cache_tag_engine_unit #(
    parameter int WAYS       = sacte_pkg::WAYS_DEF,
    parameter int SETS       = sacte_pkg::SETS_DEF,
    parameter int ADDR_BITS  = sacte_pkg::ADDR_BITS_DEF,
    parameter int STAMP_BITS = sacte_pkg::STAMP_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sacte_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sacte_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ADDR_BITS-1:0]                address,
    input  logic                                func,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic                                prefetch_filled,
    output logic [1:0]                          mem_reads,
    output logic                                mem_write,
    output logic [sacte_pkg::TOTAL_W-1:0]       total_hits,
    output logic [sacte_pkg::TOTAL_W-1:0]       total_misses,
    output logic [sacte_pkg::TOTAL_W-1:0]       total_reads,
    output logic [sacte_pkg::TOTAL_W-1:0]       total_writes
);
    import sacte_pkg::*;
    `include "set_assoc_cache_tag_engine_unit_macros.svh"

    localparam int WAY_W  = 1 + ADDR_BITS + 2 * STAMP_BITS;
    localparam int ROW_W  = WAYS * WAY_W;
    localparam int TAG_O  = 1;
    localparam int FILL_O = 1 + ADDR_BITS;
    localparam int USE_O  = 1 + ADDR_BITS + STAMP_BITS;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SB_MAX = $clog2(SETS + 1) - 1;
    localparam int IW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W   = $clog2(WAYS + 1);

    typedef enum logic [4:0] {
        ST_CLEAR   = 5'b00001,
        ST_IDLE    = 5'b00010,
        ST_LOOK    = 5'b00100,
        ST_PF_LOOK = 5'b01000,
        ST_DONE    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic           lru_reg, pf_en_reg;
    logic [3:0]     off_reg, sb_cfg_reg, ways_cfg_reg;
    logic [SET_W-1:0] clr_reg;

    logic [STAMP_BITS-1:0] acc_reg;
    logic [TOTAL_W-1:0]    hits_reg, misses_reg, reads_reg, writes_reg;

    logic [ADDR_BITS-1:0] addr_reg;
    logic                 func_reg;
    logic [SET_W-1:0]     set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic                 fwd_reg;
    logic [ROW_W-1:0]     wrow_reg;
    logic                 res_hit_reg, res_pf_reg;
    logic [1:0]           res_reads_reg;

    logic                 out_valid_reg;
    logic                 o_hit_reg, o_pf_reg, o_wr_reg;
    logic [1:0]           o_reads_reg;
    logic [TOTAL_W-1:0]   o_hits_reg, o_misses_reg, o_reads_tot_reg, o_writes_reg;

    logic [3:0]           sb_eff;
    logic [NW_W-1:0]      nw;
    logic                 in_acc, out_free, pf_go;
    logic [SET_W-1:0]     in_set, nx_set;
    logic [ADDR_BITS-1:0] in_tag, nx_tag, nx_addr;
    logic [ROW_W-1:0]     rd_row, row_cur, row_new;
    logic [STAMP_BITS-1:0] cnt;
    logic                 is_wr;
    sel_t                 sel;
    logic [IW-1:0]        wsel;

    logic                 ram_we, ram_re;
    logic [SET_W-1:0]     ram_waddr, ram_raddr;
    logic [ROW_W-1:0]     ram_wdata;

    function automatic logic [SET_W-1:0] set_of(input logic [ADDR_BITS-1:0] a,
                                                 input logic [3:0] off,
                                                 input logic [3:0] sb);
        logic [ADDR_BITS-1:0] sh;
        logic [SET_W:0]       mask;
        sh   = a >> off;
        mask = (SET_W+1)'(1) << sb;
        mask = mask - (SET_W+1)'(1);
        return SET_W'(sh) & mask[SET_W-1:0];
    endfunction

    function automatic logic [ADDR_BITS-1:0] tag_of(input logic [ADDR_BITS-1:0] a,
                                                     input logic [3:0] off,
                                                     input logic [3:0] sb);
        logic [4:0] amt;
        amt = {1'b0, off} + {1'b0, sb};
        return a >> amt;
    endfunction

    assign sb_eff = (sb_cfg_reg > 4'(SB_MAX)) ? 4'(SB_MAX) : sb_cfg_reg;
    always_comb
    begin
        if (ways_cfg_reg == 4'd0)
        begin
            nw = NW_W'(1);
        end
        else if ({1'b0, ways_cfg_reg} > 5'(WAYS))
        begin
            nw = NW_W'(WAYS);
        end
        else
        begin
            nw = NW_W'(ways_cfg_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) || (state_reg == ST_DONE && out_free);
    assign in_acc    = in_valid && in_ready;

    assign in_set  = set_of(address, off_reg, sb_eff);
    assign in_tag  = tag_of(address, off_reg, sb_eff);
    assign nx_addr = addr_reg + (ADDR_BITS'(1) << off_reg);
    assign nx_set  = set_of(nx_addr, off_reg, sb_eff);
    assign nx_tag  = tag_of(nx_addr, off_reg, sb_eff);

    // the prefetch row may be the one just written back
    assign row_cur = (state_reg == ST_PF_LOOK && fwd_reg) ? wrow_reg : rd_row;
    assign cnt     = acc_reg + STAMP_BITS'(1);
    assign is_wr   = (state_reg == ST_LOOK) && func_reg;
    assign wsel    = sel.way[IW-1:0];
    assign pf_go   = (state_reg == ST_LOOK) && !sel.hit && pf_en_reg;

    sacte_way_sel #(
        .WAYS       (WAYS),
        .ADDR_BITS  (ADDR_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_way_sel (
        .row (row_cur),
        .tag (tag_reg),
        .nw  (nw),
        .lru (lru_reg),
        .sel (sel)
    );

    always_comb
    begin
        row_new = row_cur;
        if (sel.hit)
        begin
            if (!is_wr)
            begin
                row_new[wsel*WAY_W+USE_O +: STAMP_BITS] = cnt;
            end
        end
        else
        begin
            row_new[wsel*WAY_W]                      = 1'b1;
            row_new[wsel*WAY_W+TAG_O +: ADDR_BITS]   = tag_reg;
            row_new[wsel*WAY_W+FILL_O +: STAMP_BITS] = cnt;
            row_new[wsel*WAY_W+USE_O +: STAMP_BITS]  = cnt;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = set_reg;
        ram_wdata = row_new;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_LOOK, ST_PF_LOOK:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE, ST_DONE:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
        ram_re    = in_acc || pf_go;
        ram_raddr = pf_go ? nx_set : in_set;
    end

    sacte_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_row)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = pf_go ? ST_PF_LOOK : ST_DONE;
            end
            ST_PF_LOOK:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (in_acc)
                begin
                    state_next = ST_LOOK;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            lru_reg       <= 1'b0;
            pf_en_reg     <= 1'b0;
            off_reg       <= OFFSET_BITS_RST;
            sb_cfg_reg    <= SET_BITS_RST;
            ways_cfg_reg  <= WAYS_IN_USE_RST;
            acc_reg       <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            reads_reg     <= '0;
            writes_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + SET_W'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_REPLACE_LRU:     lru_reg      <= cfg_data[0];
                    CFG_PREFETCH_ENABLE: pf_en_reg    <= cfg_data[0];
                    CFG_OFFSET_BITS:     off_reg      <= cfg_data;
                    CFG_SET_BITS:        sb_cfg_reg   <= cfg_data;
                    CFG_WAYS_IN_USE:     ways_cfg_reg <= cfg_data;
                    default:             ;
                endcase
            end
            if (state_reg == ST_LOOK)
            begin
                acc_reg <= cnt;
                if (sel.hit)
                begin
                    hits_reg <= sat_inc(hits_reg);
                end
                else
                begin
                    misses_reg <= sat_inc(misses_reg);
                    reads_reg  <= sat_inc(reads_reg);
                end
                if (func_reg)
                begin
                    writes_reg <= sat_inc(writes_reg);
                end
            end
            if (state_reg == ST_PF_LOOK)
            begin
                acc_reg <= cnt;
                if (!sel.hit)
                begin
                    reads_reg <= sat_inc(reads_reg);
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            addr_reg <= address;
            func_reg <= func;
            set_reg  <= in_set;
            tag_reg  <= in_tag;
        end
        if (state_reg == ST_LOOK)
        begin
            res_hit_reg   <= sel.hit;
            res_pf_reg    <= 1'b0;
            res_reads_reg <= sel.hit ? 2'd0 : 2'd1;
            if (pf_go)
            begin
                set_reg  <= nx_set;
                tag_reg  <= nx_tag;
                fwd_reg  <= (nx_set == set_reg);
                wrow_reg <= row_new;
            end
        end
        if (state_reg == ST_PF_LOOK && !sel.hit)
        begin
            res_pf_reg    <= 1'b1;
            res_reads_reg <= 2'd2;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            o_hit_reg       <= res_hit_reg;
            o_pf_reg        <= res_pf_reg;
            o_reads_reg     <= res_reads_reg;
            o_wr_reg        <= func_reg;
            o_hits_reg      <= hits_reg;
            o_misses_reg    <= misses_reg;
            o_reads_tot_reg <= reads_reg;
            o_writes_reg    <= writes_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = o_hit_reg;
    assign prefetch_filled = o_pf_reg;
    assign mem_reads       = o_reads_reg;
    assign mem_write       = o_wr_reg;
    assign total_hits      = o_hits_reg;
    assign total_misses    = o_misses_reg;
    assign total_reads     = o_reads_tot_reg;
    assign total_writes    = o_writes_reg;

    `SACTE_ASSERT_NEXT(a_accept_to_look, in_valid && in_ready, state_reg == ST_LOOK,
        "accepted request did not start a lookup")
    `SACTE_ASSERT_NOW(a_no_accept_clear, state_reg == ST_CLEAR, !in_ready,
        "request accepted during ram clear")
    `SACTE_ASSERT_NOW(a_hit_no_reads, out_valid && hit, mem_reads == 2'd0 && !prefetch_filled,
        "hit result reports memory reads")
    `SACTE_ASSERT_NOW(a_pf_two_reads, out_valid && prefetch_filled, mem_reads == 2'd2,
        "prefetch fill without two reads")

endmodule

>>> tb/set_assoc_cache_tag_engine_unit_tb.sv
// self-checking testbench of the cache tag engine: predictor, driver, monitor
`timescale 1ns / 1ps
module set_assoc_cache_tag_engine_unit_tb;
    import sacte_pkg::*;

    localparam int WAYS = WAYS_DEF;
    localparam int SETS = SETS_DEF;
    localparam int AB   = ADDR_BITS_DEF;
    localparam int SB   = STAMP_BITS_DEF;

    typedef struct packed {
        logic [AB-1:0] address;
        logic          func;
    } access_t;

    typedef struct packed {
        logic              hit;
        logic              prefetch_filled;
        logic [1:0]        mem_reads;
        logic              mem_write;
        logic [TOTAL_W-1:0] total_hits;
        logic [TOTAL_W-1:0] total_misses;
        logic [TOTAL_W-1:0] total_reads;
        logic [TOTAL_W-1:0] total_writes;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [AB-1:0] address;
    logic func;
    logic out_valid;
    logic out_ready;
    logic hit;
    logic prefetch_filled;
    logic [1:0] mem_reads;
    logic mem_write;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_reads;
    logic [TOTAL_W-1:0] total_writes;

    set_assoc_cache_tag_engine_unit dut (.*);

    // predictor state
    logic [AB-1:0] tag_mem [SETS*WAYS];
    logic          vld_mem [SETS*WAYS];
    logic [SB-1:0] fill_mem [SETS*WAYS];
    logic [SB-1:0] used_mem [SETS*WAYS];
    logic [SB-1:0] tick;
    logic [TOTAL_W-1:0] n_hit, n_miss, n_rd, n_wr;
    logic       pol_lru, pf_on;
    logic [3:0] off_b, set_b, ways_b;

    access_t  pending_reqs[$];
    outcome_t expected_outcomes[$];
    int mismatches;

    logic in_ready_s;
    int hold_off;
    bit burst;
    int gap_left;
    int stall_left;
    int stall_now;
    bit out_acc_s;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // one set lookup with fill on miss; returns hit
    function automatic logic probe(input logic [AB-1:0] a, input logic wr,
                                   output logic filled);
        int sb, nw, base, victim;
        logic [AB-1:0] tg;
        logic found_inv;
        sb = 0;
        while (sb < set_b && (1 << (sb + 1)) <= SETS) sb++;
        nw = (ways_b == 0) ? 1 : (ways_b > WAYS) ? WAYS : ways_b;
        base = int'((a >> off_b) & ((64'd1 << sb) - 1)) * WAYS;
        tg = a >> (off_b + sb);
        tick = tick + 1'b1;
        filled = 1'b0;
        for (int w = 0; w < nw; w++)
            if (vld_mem[base+w] && tag_mem[base+w] == tg)
            begin
                if (!wr) used_mem[base+w] = tick;
                return 1'b1;
            end
        found_inv = 1'b0;
        victim = 0;
        for (int w = 0; w < nw; w++)
            if (!vld_mem[base+w] && !found_inv)
            begin
                victim = w;
                found_inv = 1'b1;
            end
        if (!found_inv)
            for (int w = 1; w < nw; w++)
                if (pol_lru ? (used_mem[base+w] < used_mem[base+victim])
                            : (fill_mem[base+w] < fill_mem[base+victim]))
                    victim = w;
        vld_mem[base+victim]  = 1'b1;
        tag_mem[base+victim]  = tg;
        fill_mem[base+victim] = tick;
        used_mem[base+victim] = tick;
        filled = 1'b1;
        return 1'b0;
    endfunction

    function automatic outcome_t predict_access(input access_t r);
        outcome_t o;
        logic f, pf;
        logic h;
        o = '0;
        pf = 1'b0;
        h = probe(r.address, r.func, f);
        o.mem_reads = 2'd0;
        if (h) n_hit = bump(n_hit);
        else
        begin
            n_miss = bump(n_miss);
            n_rd = bump(n_rd);
            o.mem_reads = 2'd1;
            if (pf_on)
            begin
                void'(probe(r.address + (AB'(1) << off_b), 1'b0, pf));
                if (pf)
                begin
                    n_rd = bump(n_rd);
                    o.mem_reads = 2'd2;
                end
            end
        end
        if (r.func) n_wr = bump(n_wr);
        o.hit = h;
        o.prefetch_filled = pf;
        o.mem_write = r.func;
        o.total_hits = n_hit;
        o.total_misses = n_miss;
        o.total_reads = n_rd;
        o.total_writes = n_wr;
        return o;
    endfunction

    // driver: requests from the queue, random gap after each unless in burst
    initial
    begin
        in_valid = 1'b0;
        address = '0;
        func = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_ready_s)
            begin
                // still waiting, hold the request
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() > 0 && hold_off == 0)
            begin
                in_valid <= 1'b1;
                address <= pending_reqs[0].address;
                func <= pending_reqs[0].func;
                void'(pending_reqs.pop_front());
                gap_left <= burst ? 0 : $urandom_range(0, 10);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        in_ready_s <= in_ready;
        if (in_valid && in_ready)
        begin
            expected_outcomes.push_back(predict_access('{address, func}));
        end
    end

    // monitor and receiver stall
    initial out_ready = 1'b0;

    always @(posedge clk)
    begin
        out_acc_s <= out_valid && out_ready;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (out_acc_s && !burst)
        begin
            stall_now = $urandom_range(0, 10);
            out_ready <= (stall_now == 0);
            stall_left <= (stall_now > 0) ? stall_now - 1 : 0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            outcome_t got, want;
            got = '{hit, prefetch_filled, mem_reads, mem_write,
                    total_hits, total_misses, total_reads, total_writes};
            if (expected_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
                end
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [3:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_REPLACE_LRU:     pol_lru = val[0];
            CFG_PREFETCH_ENABLE: pf_on = val[0];
            CFG_OFFSET_BITS:     off_b = val;
            CFG_SET_BITS:        set_b = val;
            CFG_WAYS_IN_USE:     ways_b = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0);
        @(posedge clk);
        while (in_valid || expected_outcomes.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // addresses mostly inside a small window so sets fill and evict
    function automatic access_t rand_access();
        access_t r;
        logic [AB-1:0] a;
        a = AB'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0, 1: r.address = a;
            default: r.address = AB'($urandom_range(0, 63)) << off_b
                                 | (a & ((AB'(1) << off_b) - 1))
                                 | (AB'($urandom_range(0, 3)) << 20);
        endcase
        r.func = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic phase(input logic lru, input logic pf, input logic [3:0] ob,
                         input logic [3:0] sb, input logic [3:0] wb, input int n);
        write_reg(CFG_REPLACE_LRU, {3'b0, lru});
        write_reg(CFG_PREFETCH_ENABLE, {3'b0, pf});
        write_reg(CFG_OFFSET_BITS, ob);
        write_reg(CFG_SET_BITS, sb);
        write_reg(CFG_WAYS_IN_USE, wb);
        for (int i = 0; i < n; i++) pending_reqs.push_back(rand_access());
        drain();
    endtask

    initial
    begin
        mismatches = 0;
        gap_left = 0;
        stall_left = 0;
        hold_off = 0;
        burst = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < SETS*WAYS; i++)
        begin
            tag_mem[i] = '0;
            vld_mem[i] = 1'b0;
            fill_mem[i] = '0;
            used_mem[i] = '0;
        end
        tick = '0;
        {n_hit, n_miss, n_rd, n_wr} = '0;
        pol_lru = 1'b0;
        pf_on = 1'b0;
        off_b = OFFSET_BITS_RST;
        set_b = SET_BITS_RST;
        ways_b = WAYS_IN_USE_RST;
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, repeat hit, write hit, then prefetch with a top-address hit and a miss at zero
        pending_reqs.push_back('{'0, 1'b0});
        pending_reqs.push_back('{'0, 1'b0});
        pending_reqs.push_back('{'0, 1'b1});
        pending_reqs.push_back('{'1, 1'b1});
        pending_reqs.push_back('{'1, 1'b0});
        pending_reqs.push_back('{48'h5555_5555_5555, 1'b0});
        pending_reqs.push_back('{48'hAAAA_AAAA_AAAA, 1'b1});
        for (int i = 0; i < 10; i++)
            pending_reqs.push_back('{AB'(i) << 14, i[0]});
        drain();
        write_reg(CFG_PREFETCH_ENABLE, 4'd1);
        pending_reqs.push_back('{'1, 1'b0});
        pending_reqs.push_back('{'0, 1'b0});
        pending_reqs.push_back('{48'h40, 1'b1});
        drain();

        phase(1'b0, 1'b0, 4'd6, 4'd8, 4'd8, 250);
        phase(1'b1, 1'b0, 4'd0, 4'd2, 4'd4, 250);
        phase(1'b1, 1'b1, 4'd4, 4'd0, 4'd1, 200);
        phase(1'b0, 1'b1, 4'd15, 4'd15, 4'd0, 200);
        burst = 1'b1;
        phase(1'b1, 1'b1, 4'd12, 4'd8, 4'd15, 250);
        burst = 1'b0;
        phase(1'b0, 1'b1, 4'd2, 4'd3, 4'd2, 250);
        phase(1'b1, 1'b0, 4'd5, 4'd1, 4'd8, 200);
        phase(1'b1, 1'b1, 4'd6, 4'd4, 4'd3, 200);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/sacte_pkg.sv
src/sacte_ram.sv
src/sacte_way_sel.sv
src/set_assoc_cache_tag_engine_unit.sv
tb/set_assoc_cache_tag_engine_unit_tb.sv
